>>> rtl/mpoc_pkg.sv
// shared constants for the multi-pattern occurrence counter
// item codes and default sizes; no dependencies
package mpoc_pkg;

    // default sizes
    localparam int NODE_COUNT_DEF    = 4096;
    localparam int PATTERN_SLOTS_DEF = 1024;
    localparam int ALPHABET_SIZE_DEF = 27;

    // field widths
    localparam int ACTION_W = 3;
    localparam int SYMBOL_W = 5;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 32;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PATTERN   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TEXT      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_BUILD     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PROPAGATE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd4;

endpackage

>>> rtl/mpoc_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module mpoc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/multi_pattern_occurrence_counter.sv
// top level of the multi-pattern occurrence counter (aho-corasick with counts)
// uses mpoc_pkg and mpoc_ram for the node, link, order, count and slot tables
//
// usage:
//  slave stream carries one item per handshake: action, symbol, pattern index
//  in tdata and the last-symbol mark in tlast. the master stream returns one
//  item per query: slot, saturating occurrence count and sticky overflow flag.
//  actions: pattern symbol inserts into the trie, text symbol advances the
//  matcher and counts a visit, build computes failure links breadth first,
//  propagate adds counts down failure links, query reads a slot's count.
//  one item is worked at a time by a small sequencer over the table memories;
//  tready is low until it is done. a text symbol follows failure links as
//  needed; build scans each symbol slot of every trie node and walks
//  failure links; propagate visits the nodes in reverse breadth-first order.
//  after reset a clearing pass zeroes the tables; no item is taken meanwhile.
//  a stalled receiver holds the result register; a query then waits at its end.
module multi_pattern_occurrence_counter #(
    parameter int NODE_COUNT    = mpoc_pkg::NODE_COUNT_DEF,
    parameter int PATTERN_SLOTS = mpoc_pkg::PATTERN_SLOTS_DEF,
    parameter int ALPHABET_SIZE = mpoc_pkg::ALPHABET_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // action [2:0], symbol [7:3], pattern_index [17:8], zero fill
    input  logic [23:0] i_s_tdata,
    // last
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // pattern_number [9:0], match_count [41:10], overflow [42], zero fill
    output logic [47:0] o_m_tdata
);
    localparam int NW      = $clog2(NODE_COUNT);
    localparam int CD      = NODE_COUNT * ALPHABET_SIZE;
    localparam int CW      = $clog2(CD);
    localparam int PW      = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
    localparam int SW      = $clog2(ALPHABET_SIZE);
    localparam int CLR_LEN = (CD > PATTERN_SLOTS) ? CD : PATTERN_SLOTS;
    localparam int LW      = $clog2(CLR_LEN);
    localparam int KW      = mpoc_pkg::COUNT_W;
    localparam int IW      = mpoc_pkg::INDEX_W;

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_PAT    = 5'd2;
    localparam logic [4:0] S_PAT2   = 5'd3;
    localparam logic [4:0] S_PATEND = 5'd4;
    localparam logic [4:0] S_TXT    = 5'd5;
    localparam logic [4:0] S_TXT1   = 5'd6;
    localparam logic [4:0] S_TXT2   = 5'd7;
    localparam logic [4:0] S_TXT3   = 5'd8;
    localparam logic [4:0] S_TXT4   = 5'd9;
    localparam logic [4:0] S_TXTEND = 5'd10;
    localparam logic [4:0] S_BNODE  = 5'd11;
    localparam logic [4:0] S_BNQ    = 5'd12;
    localparam logic [4:0] S_BCH    = 5'd13;
    localparam logic [4:0] S_BCHQ   = 5'd14;
    localparam logic [4:0] S_BF     = 5'd15;
    localparam logic [4:0] S_BFQ    = 5'd16;
    localparam logic [4:0] S_BFF    = 5'd17;
    localparam logic [4:0] S_P      = 5'd18;
    localparam logic [4:0] S_P1     = 5'd19;
    localparam logic [4:0] S_P2     = 5'd20;
    localparam logic [4:0] S_P3     = 5'd21;
    localparam logic [4:0] S_P4     = 5'd22;
    localparam logic [4:0] S_Q      = 5'd23;
    localparam logic [4:0] S_Q1     = 5'd24;
    localparam logic [4:0] S_Q2     = 5'd25;
    localparam logic [4:0] S_QOUT   = 5'd26;

    logic [4:0]    r_state;
    logic [LW-1:0] r_clr;
    logic [mpoc_pkg::SYMBOL_W-1:0] r_isym;
    logic          r_last;
    logic [IW-1:0] r_slot;
    logic [NW-1:0] r_node, r_match, r_used, r_bnode, r_ch, r_f, r_pn, r_pf;
    logic [NW:0]   r_len, r_head, r_k, r_guard;
    logic [SW-1:0] r_bsym;
    logic          r_ovf, r_drop, r_atroot;
    logic [KW-1:0] r_vn, r_cnt;
    logic          r_ovalid;
    logic [IW-1:0] r_onum;
    logic [KW-1:0] r_ocnt;
    logic          r_oovf;

    // memory ports
    logic          c_we;
    logic [CW-1:0] c_waddr, c_raddr;
    logic [NW-1:0] c_wdata, c_q;
    logic          f_we;
    logic [NW-1:0] f_waddr, f_wdata, f_raddr, f_q;
    logic          v_we;
    logic [NW-1:0] v_waddr, v_raddr;
    logic [KW-1:0] v_wdata, v_q;
    logic          b_we;
    logic [NW-1:0] b_waddr, b_wdata, b_raddr, b_q;
    logic          p_we;
    logic [PW-1:0] p_waddr, p_raddr;
    logic [NW-1:0] p_wdata, p_q;

    logic [NW-1:0] rd_node;
    logic [CW-1:0] rd_sym;
    logic [KW:0]   sa_sum;
    logic [KW-1:0] sa_b, sa_res;
    logic          sym_ok, slot_ok, pool_full, walk_on, bsym_end;
    logic [NW-1:0] f_final;

    assign sym_ok    = (32'(r_isym) < ALPHABET_SIZE);
    assign slot_ok   = (32'(r_slot) < PATTERN_SLOTS);
    assign pool_full = ((32'(r_used) + 32'd1) >= NODE_COUNT);
    assign bsym_end  = (r_bsym == SW'(ALPHABET_SIZE - 1));
    assign walk_on   = (32'(r_guard) < NODE_COUNT) && (r_f != '0) && (c_q == '0);
    assign f_final   = ((r_f != r_bnode) && (c_q != '0)) ? c_q : r_f;

    // shared saturating adder: visit increment or count propagation
    assign sa_b   = (r_state == S_TXT4) ? KW'(1) : r_vn;
    assign sa_sum = {1'b0, v_q} + {1'b0, sa_b};
    assign sa_res = sa_sum[KW] ? '1 : sa_sum[KW-1:0];

    // child table address: node times alphabet plus symbol
    always_comb begin
        case (r_state)
            S_TXT:       begin rd_node = r_match; rd_sym = CW'(r_isym); end
            S_BCH:       begin rd_node = r_bnode; rd_sym = CW'(r_bsym); end
            S_BF:        begin rd_node = r_f;     rd_sym = CW'(r_bsym); end
            default:     begin rd_node = r_node;  rd_sym = CW'(r_isym); end
        endcase
    end
    assign c_raddr = CW'(CW'(rd_node) * CW'(ALPHABET_SIZE)) + rd_sym;

    // read address selection
    always_comb begin
        case (r_state)
            S_BCH:   f_raddr = r_bnode;
            S_BFQ:   f_raddr = r_f;
            S_P1:    f_raddr = b_q;
            default: f_raddr = r_match;
        endcase
        case (r_state)
            S_P2:    v_raddr = r_pn;
            S_P3:    v_raddr = r_pf;
            S_Q1:    v_raddr = p_q;
            default: v_raddr = r_match;
        endcase
        b_raddr = (r_state == S_P) ? NW'(r_k - 1'b1) : r_head[NW-1:0];
        p_raddr = PW'(r_slot);
    end

    // write port selection
    always_comb begin
        c_we = 1'b0; c_waddr = c_raddr; c_wdata = r_used + 1'b1;
        f_we = 1'b0; f_waddr = r_ch;    f_wdata = f_final;
        v_we = 1'b0; v_waddr = r_match; v_wdata = sa_res;
        b_we = 1'b0; b_waddr = r_len[NW-1:0]; b_wdata = r_ch;
        p_we = 1'b0; p_waddr = PW'(r_slot); p_wdata = r_node;
        case (r_state)
            S_CLR: begin
                c_we = (32'(r_clr) < CD);
                c_waddr = CW'(r_clr);
                c_wdata = '0;
                f_we = (32'(r_clr) < NODE_COUNT);
                f_waddr = NW'(r_clr);
                f_wdata = '0;
                v_we = f_we;
                v_waddr = NW'(r_clr);
                v_wdata = '0;
                p_we = (32'(r_clr) < PATTERN_SLOTS);
                p_waddr = PW'(r_clr);
                p_wdata = '0;
            end
            S_PAT2:   c_we = (c_q == '0) && !pool_full;
            S_PATEND: p_we = r_last && !r_drop && slot_ok;
            S_TXT4:   v_we = 1'b1;
            S_BFQ: begin
                f_we = !walk_on;
                b_we = !walk_on && (32'(r_len) < NODE_COUNT);
            end
            S_P4: begin
                v_waddr = r_pf;
                v_we = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_node   <= '0;
            r_match  <= '0;
            r_used   <= '0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready && r_state != S_QOUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LW'(CLR_LEN - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_isym  <= i_s_tdata[7:3];
                        r_last  <= i_s_tlast;
                        r_slot  <= i_s_tdata[17:8];
                        r_guard <= '0;
                        case (i_s_tdata[2:0])
                            mpoc_pkg::ACT_PATTERN: r_state <= S_PAT;
                            mpoc_pkg::ACT_TEXT:    r_state <= S_TXT;
                            mpoc_pkg::ACT_BUILD: begin
                                r_len    <= '0;
                                r_head   <= '0;
                                r_atroot <= 1'b1;
                                r_state  <= S_BNODE;
                            end
                            mpoc_pkg::ACT_PROPAGATE: begin
                                r_k     <= r_len;
                                r_state <= S_P;
                            end
                            mpoc_pkg::ACT_QUERY:   r_state <= S_Q;
                            default:               r_state <= S_IDLE;
                        endcase
                    end
                end
                // pattern insertion
                S_PAT:    r_state <= (!r_drop && sym_ok) ? S_PAT2 : S_PATEND;
                S_PAT2: begin
                    if (c_q != '0) begin
                        r_node <= c_q;
                    end else if (pool_full) begin
                        r_ovf  <= 1'b1;
                        r_drop <= 1'b1;
                    end else begin
                        r_used <= r_used + 1'b1;
                        r_node <= r_used + 1'b1;
                    end
                    r_state <= S_PATEND;
                end
                S_PATEND: begin
                    if (r_last) begin
                        r_node <= '0;
                        r_drop <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                // text matching
                S_TXT:    r_state <= sym_ok ? S_TXT1 : S_TXTEND;
                S_TXT1: begin
                    if (r_match != '0 && c_q == '0 && 32'(r_guard) < NODE_COUNT) begin
                        r_state <= S_TXT2;
                    end else begin
                        if (c_q != '0) r_match <= c_q;
                        r_state <= S_TXT3;
                    end
                end
                S_TXT2: begin
                    r_match <= f_q;
                    r_guard <= r_guard + 1'b1;
                    r_state <= S_TXT;
                end
                S_TXT3:   r_state <= S_TXT4;
                S_TXT4:   r_state <= S_TXTEND;
                S_TXTEND: begin
                    if (r_last) r_match <= '0;
                    r_state <= S_IDLE;
                end
                // failure link build
                S_BNODE: begin
                    if (r_atroot) begin
                        r_atroot <= 1'b0;
                        r_bnode  <= '0;
                        r_bsym   <= '0;
                        r_state  <= S_BCH;
                    end else if (r_head >= r_len) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_BNQ;
                    end
                end
                S_BNQ: begin
                    r_bnode <= b_q;
                    r_head  <= r_head + 1'b1;
                    r_bsym  <= '0;
                    r_state <= S_BCH;
                end
                S_BCH:    r_state <= S_BCHQ;
                S_BCHQ: begin
                    if (c_q == '0) begin
                        r_bsym  <= r_bsym + 1'b1;
                        r_state <= bsym_end ? S_BNODE : S_BCH;
                    end else begin
                        r_ch    <= c_q;
                        r_f     <= f_q;
                        r_guard <= '0;
                        r_state <= S_BF;
                    end
                end
                S_BF:     r_state <= S_BFQ;
                S_BFQ: begin
                    if (walk_on) begin
                        r_state <= S_BFF;
                    end else begin
                        if (32'(r_len) < NODE_COUNT) r_len <= r_len + 1'b1;
                        r_bsym  <= r_bsym + 1'b1;
                        r_state <= bsym_end ? S_BNODE : S_BCH;
                    end
                end
                S_BFF: begin
                    r_f     <= f_q;
                    r_guard <= r_guard + 1'b1;
                    r_state <= S_BF;
                end
                // count propagation in reverse order
                S_P: begin
                    if (r_k == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_P1;
                    end
                end
                S_P1: begin
                    r_pn    <= b_q;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_pf    <= f_q;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_vn    <= v_q;
                    r_state <= S_P4;
                end
                S_P4:     r_state <= S_P;
                // query
                S_Q:      r_state <= S_Q1;
                S_Q1:     r_state <= S_Q2;
                S_Q2: begin
                    r_cnt   <= slot_ok ? v_q : '0;
                    r_state <= S_QOUT;
                end
                S_QOUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_onum   <= r_slot;
                        r_ocnt   <= r_cnt;
                        r_oovf   <= r_ovf;
                        r_state  <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_oovf, r_ocnt, r_onum};

    // table memories
    mpoc_ram #(.W(NW), .D(CD)) u_child (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_q)
    );
    mpoc_ram #(.W(NW), .D(NODE_COUNT)) u_fail (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_q)
    );
    mpoc_ram #(.W(KW), .D(NODE_COUNT)) u_visit (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_q)
    );
    mpoc_ram #(.W(NW), .D(NODE_COUNT)) u_order (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(b_raddr), .o_rdata(b_q)
    );
    mpoc_ram #(.W(NW), .D(PATTERN_SLOTS)) u_pend (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_q)
    );
endmodule
